/* rtl/windowed_autocorrelation_accumulator_top_defines.svh */
// Assertion macros shared by the checker of the autocorrelation accumulator.
`ifndef WINDOWED_AUTOCORRELATION_ACCUMULATOR_TOP_DEFINES_SVH
`define WINDOWED_AUTOCORRELATION_ACCUMULATOR_TOP_DEFINES_SVH

// Property checked at every clock edge while reset is released.
`define WACA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define WACA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/waca_pkg.sv */
// Shared types and constants of the windowed autocorrelation accumulator.
package waca_pkg;

    localparam int REQ_BITS     = 2;
    localparam int LAG_IDX_BITS = 8;
    localparam int OUT_SUM_BITS = 48;
    localparam int QUEUE_DEPTH  = 4;

    // Request codes on the input channel.
    localparam logic [REQ_BITS-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

    // Command kinds kept in the queue after classification.
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_READ,
        OP_CLEAR
    } t_op;

    // Head of the command queue as seen by the execution side.
    typedef struct packed {
        logic valid;
        t_op  op;
        logic in_range;
    } t_cmd_ctl;

endpackage

/* rtl/windowed_autocorrelation_accumulator_top.sv */
// Top level of the windowed autocorrelation accumulator.
//
//   channel  direction  beat fields                         handshake
//   in       to block   req_type, sample, lag_index         i_in_valid / o_in_stall
//   out      from block lag_sum, saturated                  o_out_valid / i_out_stall
//
// In the execution side a push and a clear are handled in the idle state, and a
// read passes through the read state after waiting for the output register to
// empty. The push that fills a window starts MAX_LAG * (MAX_LAG - MIN_LAG)
// multiply-accumulates on the single MAC engine, one per cycle, and then waits
// in the drain state until its pipeline is empty. The one read port of the
// lag-sum memory and the single multiplier set this rate.
// Reset is synchronous and needs no clearing pass: lag sums carry valid bits.
// The command queue takes beats while the MAC engine runs and stalls when full.
//
// Structure: the front classifies each beat and queues push, read and clear
// commands (unused request codes are dropped there). The back owns the
// ping-pong sample windows, the lag-sum memory and the MAC pipeline:
// read the two samples, multiply, then add with saturation and write back.
// A one-entry bypass covers a lag entry that is read while it is written.
// The first window after reset or clear closes without accumulating, since
// the previous window is all zero then and would add nothing.
module windowed_autocorrelation_accumulator_top #(
    parameter int MAX_LAG     = 256,
    parameter int MIN_LAG     = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [waca_pkg::REQ_BITS-1:0]     i_req_type,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    input  logic [waca_pkg::LAG_IDX_BITS-1:0] i_lag_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [waca_pkg::OUT_SUM_BITS-1:0] o_lag_sum,
    output logic                              o_saturated
);
    import waca_pkg::*;

    // Queue head handed from the front to the back, and the back's pop.
    t_cmd_ctl                w_cmd;
    logic [SAMPLE_BITS-1:0]  w_cmd_sample;
    logic [LAG_IDX_BITS-1:0] w_cmd_lag_index;
    logic                    w_cmd_pop;

    waca_front #(
        .MAX_LAG     (MAX_LAG),
        .MIN_LAG     (MIN_LAG),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_sample        (i_sample),
        .i_lag_index     (i_lag_index),
        .o_cmd           (w_cmd),
        .o_cmd_sample    (w_cmd_sample),
        .o_cmd_lag_index (w_cmd_lag_index),
        .i_cmd_pop       (w_cmd_pop)
    );

    waca_back #(
        .MAX_LAG     (MAX_LAG),
        .MIN_LAG     (MIN_LAG),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cmd_sample    (w_cmd_sample),
        .i_cmd_lag_index (w_cmd_lag_index),
        .o_cmd_pop       (w_cmd_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_lag_sum       (o_lag_sum),
        .o_saturated     (o_saturated)
    );

endmodule

/* rtl/waca_front.sv */
// Request classifier and command queue of the autocorrelation accumulator.
module waca_front #(
    parameter int MAX_LAG     = 256,
    parameter int MIN_LAG     = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [waca_pkg::REQ_BITS-1:0]    i_req_type,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic [waca_pkg::LAG_IDX_BITS-1:0] i_lag_index,
    output waca_pkg::t_cmd_ctl               o_cmd,
    output logic [SAMPLE_BITS-1:0]           o_cmd_sample,
    output logic [waca_pkg::LAG_IDX_BITS-1:0] o_cmd_lag_index,
    input  logic                             i_cmd_pop
);
    import waca_pkg::*;

    localparam int LAG_COUNT = MAX_LAG - MIN_LAG;
    localparam int QA        = $clog2(QUEUE_DEPTH);

    t_op                     r_q_op     [QUEUE_DEPTH];
    logic                    r_q_rng    [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0]  r_q_sample [QUEUE_DEPTH];
    logic [LAG_IDX_BITS-1:0] r_q_lag    [QUEUE_DEPTH];
    logic [QA-1:0]           r_wr_ptr;
    logic [QA-1:0]           r_rd_ptr;
    logic [QA:0]             r_count;
    logic [QA:0]             n_count;

    logic w_accept;
    logic w_keep;
    logic w_push;
    logic w_in_range;
    t_op  w_op;

    // Unused request codes are taken and dropped here.
    always_comb begin
        w_keep = 1'b1;
        w_op   = OP_PUSH;
        unique case (i_req_type)
            REQ_PUSH:  w_op = OP_PUSH;
            REQ_READ:  w_op = OP_READ;
            REQ_CLEAR: w_op = OP_CLEAR;
            default:   w_keep = 1'b0;
        endcase
    end

    assign w_in_range = 32'(i_lag_index) < 32'(LAG_COUNT);
    assign o_in_stall = r_count == (QA+1)'(QUEUE_DEPTH);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_push     = w_accept && w_keep;
    assign n_count    = r_count + (QA+1)'(w_push) - (QA+1)'(i_cmd_pop);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wr_ptr]     <= w_op;
            r_q_rng[r_wr_ptr]    <= w_in_range;
            r_q_sample[r_wr_ptr] <= i_sample;
            r_q_lag[r_wr_ptr]    <= i_lag_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_cmd.valid     = r_count != '0;
    assign o_cmd.op        = r_q_op[r_rd_ptr];
    assign o_cmd.in_range  = r_q_rng[r_rd_ptr];
    assign o_cmd_sample    = r_q_sample[r_rd_ptr];
    assign o_cmd_lag_index = r_q_lag[r_rd_ptr];

endmodule

/* rtl/waca_back.sv */
// Command execution: sample windows, lag sums and the multiply-accumulate engine.
module waca_back #(
    parameter int MAX_LAG     = 256,
    parameter int MIN_LAG     = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  waca_pkg::t_cmd_ctl                i_cmd,
    input  logic [SAMPLE_BITS-1:0]            i_cmd_sample,
    input  logic [waca_pkg::LAG_IDX_BITS-1:0] i_cmd_lag_index,
    output logic                              o_cmd_pop,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [waca_pkg::OUT_SUM_BITS-1:0] o_lag_sum,
    output logic                              o_saturated
);
    import waca_pkg::*;

    localparam int WIN_AW    = $clog2(MAX_LAG);
    localparam int LAG_COUNT = MAX_LAG - MIN_LAG;
    localparam int LAG_AW    = (LAG_COUNT > 1) ? $clog2(LAG_COUNT) : 1;
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int ACC_BITS  = ((PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS) + 1;
    localparam logic [ACC_BITS-1:0] SUM_MAX =
        {{(ACC_BITS-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MAC,
        S_DRAIN
    } t_state;

    // Sample windows, addressed {half, position}; lag entries hold {flag, sum}.
    logic [SAMPLE_BITS-1:0] r_smem [2**(WIN_AW+1)];
    logic [SUM_BITS:0]      r_lmem [LAG_COUNT];
    logic [LAG_COUNT-1:0]   r_lvalid;

    t_state                  r_state;
    logic                    r_half;
    logic [WIN_AW-1:0]       r_fill;
    logic                    r_prev_ok;
    logic [WIN_AW-1:0]       r_i;
    logic [LAG_AW-1:0]       r_k;
    logic [WIN_AW-1:0]       r_bpos;
    logic                    r_bsel;
    logic                    r_rd_rng;
    logic                    r_out_valid;
    logic [OUT_SUM_BITS-1:0] r_lag_sum;
    logic                    r_saturated;

    logic [SAMPLE_BITS-1:0]  r_a_rd;
    logic [SAMPLE_BITS-1:0]  r_b_rd;
    logic [SUM_BITS:0]       r_l_rd;
    logic                    r_l_rdv;
    logic                    r_p1_vld;
    logic [LAG_AW-1:0]       r_p1_k;
    logic                    r_p2_vld;
    logic [LAG_AW-1:0]       r_p2_k;
    logic [PROD_BITS-1:0]    r_prod;
    logic                    r_fw_vld;
    logic [LAG_AW-1:0]       r_fw_k;
    logic [SUM_BITS:0]       r_fw_data;

    logic                    w_pop;
    logic                    w_push;
    logic                    w_clear;
    logic                    w_read;
    logic                    w_win_last;
    logic                    w_issue;
    logic                    w_row_end;
    logic                    w_col_end;
    logic [WIN_AW:0]         w_next_start;
    logic                    w_wrap_start;
    logic [WIN_AW-1:0]       w_row_bpos;
    logic [WIN_AW:0]         w_a_addr;
    logic [WIN_AW:0]         w_b_addr;
    logic [WIN_AW:0]         w_s_waddr;
    logic [LAG_AW-1:0]       w_l_raddr;
    logic [SUM_BITS:0]       w_base;
    logic [ACC_BITS-1:0]     w_total;
    logic [SUM_BITS:0]       w_new_entry;
    logic                    w_rd_ok;

    always_comb begin
        w_pop = 1'b0;
        if (r_state == S_IDLE && i_cmd.valid) begin
            if (i_cmd.op == OP_READ) begin
                w_pop = !r_out_valid;
            end else begin
                w_pop = 1'b1;
            end
        end
    end

    assign o_cmd_pop = w_pop;
    assign w_push    = w_pop && i_cmd.op == OP_PUSH;
    assign w_clear   = w_pop && i_cmd.op == OP_CLEAR;
    assign w_read    = w_pop && i_cmd.op == OP_READ;

    assign w_win_last   = r_fill == WIN_AW'(MAX_LAG - 1);
    assign w_issue      = r_state == S_MAC;
    assign w_row_end    = r_k == LAG_AW'(LAG_COUNT - 1);
    assign w_col_end    = r_i == WIN_AW'(MAX_LAG - 1);
    assign w_next_start = (WIN_AW+1)'(r_i) + (WIN_AW+1)'(MIN_LAG + 1);
    assign w_wrap_start = w_next_start >= (WIN_AW+1)'(MAX_LAG);
    assign w_row_bpos   = w_wrap_start ? WIN_AW'(w_next_start - (WIN_AW+1)'(MAX_LAG))
                                       : WIN_AW'(w_next_start);

    // The earlier sample always comes from the previous half; the later one
    // starts there and moves into the current half once it passes the end.
    assign w_a_addr  = {~r_half, r_i};
    assign w_b_addr  = {(r_bsel ? r_half : ~r_half), r_bpos};
    assign w_s_waddr = {r_half, r_fill};
    assign w_l_raddr = (r_state == S_IDLE) ? LAG_AW'(i_cmd_lag_index) : r_p1_k;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_smem[w_s_waddr] <= i_cmd_sample;
        end
        r_a_rd <= r_smem[w_a_addr];
        r_b_rd <= r_smem[w_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_vld) begin
            r_lmem[r_p2_k] <= w_new_entry;
        end
        r_l_rd  <= r_lmem[w_l_raddr];
        r_l_rdv <= r_lvalid[w_l_raddr];
    end

    // The entry written in the previous cycle is newer than what the memory returned.
    always_comb begin
        if (r_fw_vld && r_fw_k == r_p2_k) begin
            w_base = r_fw_data;
        end else if (r_l_rdv) begin
            w_base = r_l_rd;
        end else begin
            w_base = '0;
        end
        w_total = ACC_BITS'(w_base[SUM_BITS-1:0]) + ACC_BITS'(r_prod);
        if (w_total > SUM_MAX) begin
            w_new_entry = {1'b1, SUM_MAX[SUM_BITS-1:0]};
        end else begin
            w_new_entry = {w_base[SUM_BITS], w_total[SUM_BITS-1:0]};
        end
    end

    assign w_rd_ok = r_rd_rng && r_l_rdv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half      <= 1'b0;
            r_fill      <= '0;
            r_prev_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_fw_vld    <= 1'b0;
            r_lvalid    <= '0;
        end else begin
            r_p1_vld  <= w_issue;
            r_p1_k    <= r_k;
            r_prod    <= PROD_BITS'(r_a_rd) * PROD_BITS'(r_b_rd);
            r_p2_vld  <= r_p1_vld;
            r_p2_k    <= r_p1_k;
            r_fw_vld  <= r_p2_vld;
            r_fw_k    <= r_p2_k;
            r_fw_data <= w_new_entry;
            if (r_p2_vld) begin
                r_lvalid[r_p2_k] <= 1'b1;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_push) begin
                        if (w_win_last) begin
                            r_fill <= '0;
                            if (r_prev_ok) begin
                                r_state <= S_MAC;
                                r_i     <= '0;
                                r_k     <= '0;
                                r_bpos  <= WIN_AW'(MIN_LAG);
                                r_bsel  <= 1'b0;
                            end else begin
                                r_half    <= ~r_half;
                                r_prev_ok <= 1'b1;
                            end
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end else if (w_clear) begin
                        r_lvalid  <= '0;
                        r_half    <= 1'b0;
                        r_fill    <= '0;
                        r_prev_ok <= 1'b0;
                    end else if (w_read) begin
                        r_rd_rng <= i_cmd.in_range;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_lag_sum   <= w_rd_ok ? OUT_SUM_BITS'(r_l_rd[SUM_BITS-1:0]) : '0;
                    r_saturated <= w_rd_ok && r_l_rd[SUM_BITS];
                    r_state     <= S_IDLE;
                end
                S_MAC: begin
                    if (w_row_end) begin
                        r_k <= '0;
                        if (w_col_end) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i    <= r_i + 1'b1;
                            r_bpos <= w_row_bpos;
                            r_bsel <= w_wrap_start;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                        if (r_bpos == WIN_AW'(MAX_LAG - 1)) begin
                            r_bpos <= '0;
                            r_bsel <= 1'b1;
                        end else begin
                            r_bpos <= r_bpos + 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_vld && !r_p2_vld) begin
                        r_half  <= ~r_half;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lag_sum   = r_lag_sum;
    assign o_saturated = r_saturated;

endmodule

/* rtl/waca_checker.sv */
// Port-level checker for the autocorrelation accumulator, bound to the top level.
`include "windowed_autocorrelation_accumulator_top_defines.svh"

module waca_checker #(
    parameter int SUM_BITS = 48
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [waca_pkg::OUT_SUM_BITS-1:0] o_lag_sum,
    input logic                              o_saturated
);
    import waca_pkg::*;

    // A saturated sum is clamped to all ones and stays there until a clear.
    localparam logic [OUT_SUM_BITS-1:0] SAT_VALUE = OUT_SUM_BITS'({SUM_BITS{1'b1}});

    `WACA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_lag_sum) && $stable(o_saturated), "stalled result beat changed")
    `WACA_ASSERT(a_out_drop, i_clk, i_rst_n, $fell(o_out_valid) |-> $past(!i_out_stall), "result beat dropped without being taken")
    `WACA_ASSERT(a_sat_value, i_clk, i_rst_n, o_out_valid && o_saturated |-> o_lag_sum == SAT_VALUE, "saturated lag sum is not at full scale")
    `WACA_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset left a result or a full queue")

endmodule

bind windowed_autocorrelation_accumulator_top waca_checker #(
    .SUM_BITS (SUM_BITS)
) u_waca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_lag_sum   (o_lag_sum),
    .o_saturated (o_saturated)
);

/* tb/tb.sv */
// Self-checking testbench for the windowed autocorrelation accumulator.
module tb;
    import waca_pkg::*;

    // The block is built with its default sizes; the predictor below uses the same ones.
    localparam int MAX_LAG     = 256;
    localparam int MIN_LAG     = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 48;
    localparam int LAG_COUNT   = MAX_LAG - MIN_LAG;

    // The request code that the block has to drop without a trace.
    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

    // Random beats to generate before the stream may stop.
    localparam int RANDOM_BEATS = 930;
    // A push that closes a window keeps the MAC engine busy for this long at most.
    localparam int DRAIN_CYCLES = MAX_LAG * LAG_COUNT + 64;
    // Length of each long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 600;
    // The limit lies several times beyond the slowest correct run.
    localparam longint RUN_LIMIT = 64'd30_000_000;

    typedef struct {
        logic [REQ_BITS-1:0]     req;
        logic [SAMPLE_BITS-1:0]  smp;
        logic [LAG_IDX_BITS-1:0] lag;
    } t_req_beat;

    typedef struct {
        logic [OUT_SUM_BITS-1:0] sum;
        logic                    sat;
    } t_lag_read;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_pattern;

    // Clock, reset and every block input start at known values.
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic [REQ_BITS-1:0]     i_req_type  = REQ_PUSH;
    logic [SAMPLE_BITS-1:0]  i_sample    = '0;
    logic [LAG_IDX_BITS-1:0] i_lag_index = '0;
    logic                    i_out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [OUT_SUM_BITS-1:0] o_lag_sum;
    logic                    o_saturated;

    // Beats waiting to be offered, and read results still owed by the block.
    t_req_beat pending_beats[$];
    t_lag_read expected_reads[$];

    // Predicted state: the ping-pong sample windows, the lag sums and their sticky flags.
    logic [SAMPLE_BITS-1:0] win_store [2*MAX_LAG];
    logic [SUM_BITS-1:0]    lag_acc   [LAG_COUNT];
    logic                   lag_sat   [LAG_COUNT];
    int unsigned            fill_pos;
    logic                   cur_half;

    // Bookkeeping for the checks and the closing summary.
    int mismatch_count  = 0;
    int reads_checked   = 0;
    int push_count      = 0;
    int clear_count     = 0;
    int windows_folded  = 0;
    int in_stall_cycles = 0;
    int beats_in        = 0;
    int holds_taken     = 0;

    // Sender and receiver pacing state.
    int             gap_left   = 0;
    int             burst_left = 0;
    int             hold_left  = 0;
    int             mode_left  = 0;
    t_stall_pattern stall_mode = STALL_NONE;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    windowed_autocorrelation_accumulator_top #(
        .MAX_LAG     (MAX_LAG),
        .MIN_LAG     (MIN_LAG),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_sample    (i_sample),
        .i_lag_index (i_lag_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_lag_sum   (o_lag_sum),
        .o_saturated (o_saturated)
    );

    // Clear brings the predicted windows and lag sums back to their reset state, so both share this.
    function automatic void wipe_model();
        foreach (win_store[j]) win_store[j] = '0;
        foreach (lag_acc[j]) begin
            lag_acc[j] = '0;
            lag_sat[j] = 1'b0;
        end
        fill_pos = 0;
        cur_half = 1'b0;
    endfunction

    // A full window correlates every sample of the previous window against the
    // sample lag positions later. Past the end of the previous window that later
    // sample wraps into the window that has just filled. Sums clamp at all ones
    // and the lag's flag sticks once any addition overflows.
    function automatic void fold_window();
        int unsigned              cur_base;
        int unsigned              prev_base;
        int unsigned              p;
        logic [SAMPLE_BITS-1:0]   later;
        logic [2*SAMPLE_BITS-1:0] prod;
        logic [SUM_BITS:0]        total;
        cur_base  = cur_half ? MAX_LAG : 0;
        prev_base = cur_half ? 0 : MAX_LAG;
        for (int i = 0; i < MAX_LAG; i++) begin
            for (int lag = MIN_LAG; lag < MAX_LAG; lag++) begin
                p     = i + lag;
                later = (p < MAX_LAG) ? win_store[prev_base + p]
                                      : win_store[cur_base + p - MAX_LAG];
                prod  = win_store[prev_base + i] * later;
                total = {1'b0, lag_acc[lag - MIN_LAG]} + prod;
                if (total[SUM_BITS]) begin
                    lag_acc[lag - MIN_LAG] = '1;
                    lag_sat[lag - MIN_LAG] = 1'b1;
                end else begin
                    lag_acc[lag - MIN_LAG] = total[SUM_BITS-1:0];
                end
            end
        end
        cur_half = ~cur_half;
        fill_pos = 0;
        windows_folded++;
    endfunction

    // Applies one accepted beat to the predicted state; a read owes one result.
    function automatic void model_beat(t_req_beat b);
        t_lag_read r;
        case (b.req)
            REQ_PUSH: begin
                win_store[(cur_half ? MAX_LAG : 0) + fill_pos] = b.smp;
                fill_pos++;
                push_count++;
                if (fill_pos >= MAX_LAG) begin
                    fold_window();
                end
            end
            REQ_READ: begin
                if (b.lag < LAG_COUNT) begin
                    r.sum = lag_acc[b.lag];
                    r.sat = lag_sat[b.lag];
                end else begin
                    r.sum = '0;
                    r.sat = 1'b0;
                end
                expected_reads.insert(expected_reads.size(), r);
            end
            REQ_CLEAR: begin
                wipe_model();
                clear_count++;
            end
            default: ;
        endcase
    endfunction

    function automatic void add_beat(logic [REQ_BITS-1:0] req, logic [SAMPLE_BITS-1:0] smp,
                                     logic [LAG_IDX_BITS-1:0] lag);
        t_req_beat b;
        b.req = req;
        b.smp = smp;
        b.lag = lag;
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    // Samples lean toward the extremes so that large products show up often.
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_BITS'($urandom_range(1, 15));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly valid lag indexes, with the range edges and the unused top codes mixed in.
    function automatic logic [LAG_IDX_BITS-1:0] random_lag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LAG_IDX_BITS'(LAG_COUNT - 1);
            2:       return LAG_IDX_BITS'($urandom_range(LAG_COUNT, 255));
            default: return LAG_IDX_BITS'($urandom_range(0, LAG_COUNT - 1));
        endcase
    endfunction

    // Stimulus, reset and the end of the run.
    initial begin
        int n;
        int roll;
        int pushes_since_clear;
        int clear_at;
        bit clear_done;

        wipe_model();

        // Directed opening: reads at both ends of the lag range and beyond it on an
        // empty block, ignored request codes, sample extremes, and clears, one of
        // them issued on an already cleared block. The last beat clears so the
        // random part starts from a fresh first window.
        add_beat(REQ_READ,   '0,        '0);
        add_beat(REQ_READ,   '1,        LAG_IDX_BITS'(LAG_COUNT - 1));
        add_beat(REQ_READ,   '0,        LAG_IDX_BITS'(LAG_COUNT));
        add_beat(REQ_READ,   '0,        '1);
        add_beat(REQ_UNUSED, '1,        '1);
        add_beat(REQ_PUSH,   '1,        '1);
        add_beat(REQ_PUSH,   '0,        '0);
        add_beat(REQ_PUSH,   16'h0001,  8'h01);
        add_beat(REQ_PUSH,   16'h8000,  8'h80);
        add_beat(REQ_UNUSED, '0,        '0);
        add_beat(REQ_READ,   16'h5A5A,  8'h01);
        add_beat(REQ_CLEAR,  16'hA5A5,  8'h5A);
        add_beat(REQ_READ,   '0,        '0);
        add_beat(REQ_CLEAR,  '1,        '1);
        add_beat(REQ_PUSH,   16'h7FFF,  8'h7F);
        add_beat(REQ_READ,   '0,        LAG_IDX_BITS'(LAG_COUNT - 1));
        add_beat(REQ_CLEAR,  '0,        '0);

        // Random part. Pushes dominate so that windows close: the first close finds
        // an all-zero previous window, the second accumulates real products. One
        // clear lands after that, and enough pushes follow it for one more close
        // of a first window, so reads see the sums wiped and staying at zero.
        n                  = 0;
        pushes_since_clear = 0;
        clear_done         = 1'b0;
        clear_at           = 2 * MAX_LAG + $urandom_range(8, 120);
        while (n < RANDOM_BEATS || !clear_done || pushes_since_clear < MAX_LAG + 8) begin
            roll = $urandom_range(0, 99);
            if (!clear_done && pushes_since_clear == clear_at) begin
                add_beat(REQ_CLEAR, SAMPLE_BITS'($urandom), LAG_IDX_BITS'($urandom));
                clear_done         = 1'b1;
                pushes_since_clear = 0;
                n++;
            end else if (roll < 80) begin
                add_beat(REQ_PUSH, random_sample(), LAG_IDX_BITS'($urandom));
                pushes_since_clear++;
                n++;
            end else if (roll < 98) begin
                add_beat(REQ_READ, SAMPLE_BITS'($urandom), random_lag());
                n++;
            end else begin
                add_beat(REQ_UNUSED, SAMPLE_BITS'($urandom), LAG_IDX_BITS'($urandom));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_reads.size() != 0) @(posedge i_clk);
        // The last beat may have closed a window; let that finish while the monitor
        // keeps watching for stray results.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d pushes, %0d clears and %0d checked reads over %0d window closes.",
                 push_count, clear_count, reads_checked, windows_folded);
        $display("Input channel stalled on %0d cycles; receiver made %0d long hold-offs.",
                 in_stall_cycles, holds_taken);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("%0t: run limit reached with %0d beats unsent, %0d results owed",
                 $time, pending_beats.size(), expected_reads.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Driver: offers beats in bursts of random length separated by random gaps.
    // The beat on the wires is folded into the predictor at the edge that accepts
    // it, and within a burst the next one goes out at that edge; a stalled beat stays put.
    always @(posedge i_clk) begin
        t_req_beat next_beat;
        t_req_beat taken_beat;
        logic      taken;
        taken = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            if (i_in_valid && o_in_stall) begin
                in_stall_cycles++;
            end
            if (taken) begin
                taken_beat.req = i_req_type;
                taken_beat.smp = i_sample;
                taken_beat.lag = i_lag_index;
                model_beat(taken_beat);
                beats_in <= beats_in + 1;
            end
            if (!i_in_valid || taken) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    next_beat = pending_beats.pop_front();
                    i_req_type  <= next_beat.req;
                    i_sample    <= next_beat.smp;
                    i_lag_index <= next_beat.lag;
                    i_in_valid  <= 1'b1;
                    // A quarter of the bursts run straight into the next one.
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between stall patterns at random intervals. Twice it holds
    // off for a long stretch so that read results back up, the command queue fills
    // and the block has to stall its input while the driver keeps offering beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_taken < 2 && beats_in >= (holds_taken == 0 ? 40 : 700)) begin
            holds_taken++;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_pattern'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Monitor: every accepted result is matched against the oldest owed read.
    always @(posedge i_clk) begin
        t_lag_read want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reads.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no read owed: expected none, got lag_sum %h sat %b",
                         $time, o_lag_sum, o_saturated);
            end else begin
                want = expected_reads.pop_front();
                reads_checked++;
                if (o_lag_sum !== want.sum) begin
                    mismatch_count++;
                    $display("%0t: lag_sum mismatch: expected %h, got %h",
                             $time, want.sum, o_lag_sum);
                end
                if (o_saturated !== want.sat) begin
                    mismatch_count++;
                    $display("%0t: saturated mismatch: expected %b, got %b",
                             $time, want.sat, o_saturated);
                end
            end
        end
    end

endmodule
